// ===== hdl/tmq_pkg.sv =====
// Shared types and constants for the tournament-tree min queue.
// No dependencies; tmq_if, tmq_cell and min_tournament_tree_queue use this package.
package tmq_pkg;

	localparam int KW = 32;
	localparam int IW = 12;
	localparam int CW = 13;
	localparam int LEVELS = 12;
	localparam int LEAF = LEVELS - 1;
	localparam int LVL_W = 4;
	localparam int CAPACITY = 4096;
	localparam logic [KW-1:0] KEY_EMPTY = '1;

	localparam logic [1:0] ACT_ADD = 2'd0;
	localparam logic [1:0] ACT_MIN = 2'd1;
	localparam logic [1:0] ACT_REM = 2'd2;
	localparam logic [1:0] ACT_DEC = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;
	localparam logic [1:0] ST_BADIDX = 2'd3;

	localparam logic [1:0] OP_UP   = 2'd0;
	localparam logic [1:0] OP_DN   = 2'd1;
	localparam logic [1:0] OP_PEEK = 2'd2;

	// token walking the chain of level cells
	typedef struct packed {
		logic          vld;
		logic [1:0]    op;
		logic [IW-1:0] idx;
		logic [KW-1:0] val;
	} tok_t;

	// one level RAM access (pair of sibling keys per word)
	typedef struct packed {
		logic            we;
		logic [IW-1:0]   waddr;
		logic [2*KW-1:0] wdata;
		logic [IW-1:0]   raddr;
	} ram_req_t;

	function automatic tok_t mk_tok(logic [1:0] op, logic [IW-1:0] idx, logic [KW-1:0] val);
		tok_t t;
		t.vld = 1'b1;
		t.op  = op;
		t.idx = idx;
		t.val = val;
		return t;
	endfunction

endpackage

// ===== hdl/tmq_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on tmq_pkg for field widths.
interface tmq_req_if;
	logic                     valid;
	logic                     ready;
	logic [1:0]               action;
	logic [tmq_pkg::IW-1:0]   entry_index;
	logic [tmq_pkg::KW-1:0]   value;
	modport source(output valid, action, entry_index, value, input ready);
	modport sink(input valid, action, entry_index, value, output ready);
endinterface

interface tmq_rsp_if;
	logic                     valid;
	logic                     ready;
	logic [tmq_pkg::IW-1:0]   result_index;
	logic [tmq_pkg::KW-1:0]   result_value;
	logic [1:0]               status;
	modport source(output valid, result_index, result_value, status, input ready);
	modport sink(input valid, result_index, result_value, status, output ready);
endinterface

// ===== hdl/min_tournament_tree_queue.sv =====
// Channel  Dir  Fields                                   Transfer
// req      in   action, entry_index, value               valid & ready
// rsp      out  result_index, result_value, status       valid & ready
//
// Twelve level cells, each with its own pair RAM; a token passes tok_s1, then up_q or dn_q,
// in each cell. Remove does two leaf reads, then two upward passes, or one upward pass
// when the last entry goes. Errors go straight to the response register.
// Reset clears the count and control registers, not the RAMs; nodes past the count read as empty, so no clear pass.
// A new request is taken while the previous response still waits in rsp.
module min_tournament_tree_queue import tmq_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	tmq_req_if.sink  req,
	tmq_rsp_if.source rsp
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PEEK1 = 3'd1;
	localparam logic [2:0] S_PEEK2 = 3'd2;
	localparam logic [2:0] S_UP1   = 3'd3;
	localparam logic [2:0] S_UP2   = 3'd4;
	localparam logic [2:0] S_DN    = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0] st_q, st_d;
	logic [CW-1:0] cnt_q, cnt_d;
	tok_t inj_q, inj_d;
	logic [IW-1:0] idx_q, last_q, r_idx_q, o_idx_q;
	logic [IW-1:0] idx_d, last_d, r_idx_d;
	logic [KW-1:0] moved_q, r_val_q, o_val_q, key;
	logic [KW-1:0] moved_d, r_val_d;
	logic [1:0] r_st_q, o_st_q, r_st_d;
	logic o_vld_q, o_load;

	tok_t up_out [LEVELS];
	tok_t dn_out [LEVELS];
	ram_req_t ram [LEVELS];
	logic [2*KW-1:0] rdata [LEVELS];
	logic [LEVELS-1:0] tin_vld;
	logic up_done, dn_done;

	for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
		localparam int DEPTH = 1 << l;
		localparam int AW = (l > 0) ? l : 1;

		tok_t tin;

		always_comb begin
			tin = '0;
			if (inj_q.vld && (((l == 0) && (inj_q.op == OP_DN)) ||
					((l == LEAF) && (inj_q.op != OP_DN))))
				tin = inj_q;
			if (l > 0) begin
				if (dn_out[(l > 0) ? l - 1 : 0].vld)
					tin = dn_out[(l > 0) ? l - 1 : 0];
			end
			if (l < LEAF) begin
				if (up_out[(l < LEAF) ? l + 1 : LEAF].vld)
					tin = up_out[(l < LEAF) ? l + 1 : LEAF];
			end
		end

		assign tin_vld[l] = tin.vld;

		tmq_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.lvl    (LVL_W'(l)),
			.cnt    (cnt_q),
			.tin    (tin),
			.rdata  (rdata[l]),
			.ram    (ram[l]),
			.up_out (up_out[l]),
			.dn_out (dn_out[l])
		);

		tmq_ram #(.WIDTH(2 * KW), .DEPTH(DEPTH)) u_ram (
			.clk   (clk),
			.we    (ram[l].we),
			.waddr (ram[l].waddr[AW-1:0]),
			.wdata (ram[l].wdata),
			.raddr (ram[l].raddr[AW-1:0]),
			.rdata (rdata[l])
		);
	end

	assign up_done = up_out[0].vld;
	assign dn_done = dn_out[LEAF].vld;
	assign key = (req.value == KEY_EMPTY) ? KEY_EMPTY - KW'(1) : req.value;

	assign req.ready = (st_q == S_IDLE);
	assign rsp.valid = o_vld_q;
	assign rsp.result_index = o_idx_q;
	assign rsp.result_value = o_val_q;
	assign rsp.status = o_st_q;

	always_comb begin
		st_d = st_q;
		cnt_d = cnt_q;
		inj_d = '0;
		idx_d = idx_q;
		last_d = last_q;
		moved_d = moved_q;
		r_idx_d = r_idx_q;
		r_val_d = r_val_q;
		r_st_d = r_st_q;
		o_load = 1'b0;
		case (st_q)
			S_IDLE: begin
				if (req.valid) begin
					r_idx_d = '0;
					r_val_d = KEY_EMPTY;
					r_st_d = ST_OK;
					st_d = S_OUT;
					case (req.action)
						ACT_ADD: begin
							if (cnt_q == CW'(CAPACITY)) begin
								r_st_d = ST_FULL;
							end else begin
								inj_d = mk_tok(OP_UP, cnt_q[IW-1:0], key);
								r_idx_d = cnt_q[IW-1:0];
								r_val_d = key;
								cnt_d = cnt_q + CW'(1);
								st_d = S_UP2;
							end
						end
						ACT_MIN: begin
							if (cnt_q == '0) begin
								r_st_d = ST_EMPTY;
							end else begin
								inj_d = mk_tok(OP_DN, '0, '0);
								st_d = S_DN;
							end
						end
						default: begin
							if ({1'b0, req.entry_index} >= cnt_q) begin
								r_st_d = ST_BADIDX;
							end else if (req.action == ACT_DEC) begin
								inj_d = mk_tok(OP_UP, req.entry_index, key);
								r_idx_d = req.entry_index;
								r_val_d = key;
								st_d = S_UP2;
							end else begin
								inj_d = mk_tok(OP_PEEK, req.entry_index, '0);
								idx_d = req.entry_index;
								last_d = IW'(cnt_q - CW'(1));
								r_idx_d = req.entry_index;
								st_d = S_PEEK1;
							end
						end
					endcase
				end
			end
			S_PEEK1: begin
				if (dn_done) begin
					r_val_d = dn_out[LEAF].val;
					inj_d = mk_tok(OP_PEEK, last_q, '0);
					st_d = S_PEEK2;
				end
			end
			S_PEEK2: begin
				if (dn_done) begin
					moved_d = dn_out[LEAF].val;
					cnt_d = {1'b0, last_q};
					inj_d = mk_tok(OP_UP, last_q, KEY_EMPTY);
					st_d = S_UP1;
				end
			end
			S_UP1: begin
				if (up_done) begin
					if (idx_q < last_q) begin
						inj_d = mk_tok(OP_UP, idx_q, moved_q);
						st_d = S_UP2;
					end else begin
						st_d = S_OUT;
					end
				end
			end
			S_UP2: begin
				if (up_done)
					st_d = S_OUT;
			end
			S_DN: begin
				if (dn_done) begin
					r_idx_d = dn_out[LEAF].idx;
					r_val_d = dn_out[LEAF].val;
					st_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!o_vld_q || rsp.ready) begin
					o_load = 1'b1;
					st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= '0;
			inj_q <= '0;
			idx_q <= '0;
			last_q <= '0;
			moved_q <= '0;
			r_idx_q <= '0;
			r_val_q <= KEY_EMPTY;
			r_st_q <= ST_OK;
			o_vld_q <= 1'b0;
			o_idx_q <= '0;
			o_val_q <= KEY_EMPTY;
			o_st_q <= ST_OK;
		end else begin
			st_q <= st_d;
			cnt_q <= cnt_d;
			inj_q <= inj_d;
			idx_q <= idx_d;
			last_q <= last_d;
			moved_q <= moved_d;
			r_idx_q <= r_idx_d;
			r_val_q <= r_val_d;
			r_st_q <= r_st_d;
			if (o_load)
				o_vld_q <= 1'b1;
			else if (rsp.ready)
				o_vld_q <= 1'b0;
			if (o_load) begin
				o_idx_q <= r_idx_q;
				o_val_q <= r_val_q;
				o_st_q <= r_st_q;
			end
		end
	end

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tin_vld))
		else $error("more than one token in the level chain");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_IDLE) |-> (tin_vld == '0))
		else $error("token alive while idle");

	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status != ST_OK)) |->
			((rsp.result_value == KEY_EMPTY) && (rsp.result_index == '0)))
		else $error("error response carries data");

endmodule

// ===== hdl/tmq_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module tmq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/tmq_cell.sv =====
// One tree level: reads a sibling pair from its level RAM, updates or selects,
// and hands the token to the level above or below. Depends on tmq_pkg.
module tmq_cell import tmq_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [LVL_W-1:0] lvl,
	input  logic [CW-1:0]   cnt,
	input  tok_t            tin,
	input  logic [2*KW-1:0] rdata,
	output ram_req_t        ram,
	output tok_t            up_out,
	output tok_t            dn_out
);

	tok_t tok_s1, up_q, dn_q, up_d, dn_d;
	logic [IW-1:0] pa, lnode, rnode;
	logic [LVL_W-1:0] sh;
	logic [CW-1:0] lstart, rstart;
	logic [KW-1:0] lo, hi, ml, mr, sib;
	logic sel;

	always_comb begin
		ram.raddr = (tin.op == OP_DN) ? tin.idx : (tin.idx >> 1);
		pa = (tok_s1.op == OP_DN) ? tok_s1.idx : (tok_s1.idx >> 1);
		lnode = {pa[IW-2:0], 1'b0};
		rnode = {pa[IW-2:0], 1'b1};
		// a node is empty when its first leaf lies at or beyond the count
		sh = LVL_W'(LEAF) - lvl;
		lstart = {1'b0, lnode} << sh;
		rstart = {1'b0, rnode} << sh;
		lo = rdata[KW-1:0];
		hi = rdata[2*KW-1:KW];
		ml = (lstart >= cnt) ? KEY_EMPTY : lo;
		mr = (rstart >= cnt) ? KEY_EMPTY : hi;
		sib = tok_s1.idx[0] ? ml : mr;
		sel = !(ml <= mr);
		ram.we = tok_s1.vld && (tok_s1.op == OP_UP);
		ram.waddr = pa;
		ram.wdata = tok_s1.idx[0] ? {tok_s1.val, ml} : {mr, tok_s1.val};
		up_d = '0;
		dn_d = '0;
		if (tok_s1.vld) begin
			case (tok_s1.op)
				OP_UP: begin
					up_d = mk_tok(OP_UP, pa, (tok_s1.val < sib) ? tok_s1.val : sib);
				end
				OP_DN: begin
					dn_d = mk_tok(OP_DN, sel ? rnode : lnode, sel ? mr : ml);
				end
				OP_PEEK: begin
					dn_d = mk_tok(OP_PEEK, tok_s1.idx, tok_s1.idx[0] ? hi : lo);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			up_q <= '0;
			dn_q <= '0;
		end else begin
			tok_s1 <= tin;
			up_q <= up_d;
			dn_q <= dn_d;
		end
	end

	assign up_out = up_q;
	assign dn_out = dn_q;

endmodule
